>>> design/fbsd_pkg.sv
// Shared constants, types and floating-point helpers of the FP4 block-scaled dot product.
package fbsd_pkg;

  localparam int BlockSize  = 32;
  localparam int DotLimit   = (BlockSize / 2) * 3072;
  localparam int DotMagW    = $clog2(DotLimit + 1);
  localparam int DotW       = DotMagW + 1;
  localparam int ContribW   = 14;
  localparam int SumW       = ((DotW > ContribW) ? DotW : ContribW) + 1;
  localparam int ExpW       = 11;
  localparam int WordW      = 66;
  localparam int FracW      = 64;
  localparam int ProdW      = DotMagW + 24;
  localparam int QueueDepth = 2;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW     = $clog2(QueueDepth + 1);

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // One closed block, handed from the front to the back.
  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [15:0]            weight_scale;
    logic [31:0]            act_scale;
    logic [31:0]            bias_value;
    logic                   end_of_row;
  } blk_job_t;

  // Unnormalised value: word * 2^(xp - 65), i.e. xp is the weight of the top word bit.
  typedef struct packed {
    logic                   nan;
    logic                   inf;
    logic                   zero;
    logic                   sign;
    logic signed [ExpW-1:0] xp;
    logic [WordW-1:0]       word;
  } pre_t;

  // Normalised value: top bit of frac set, weight of that bit is 2^xp.
  typedef struct packed {
    logic                   nan;
    logic                   inf;
    logic                   zero;
    logic                   sign;
    logic signed [ExpW-1:0] xp;
    logic [FracW-1:0]       frac;
  } unp_t;

  // Twice the E2M1 value of a code.
  function automatic logic signed [4:0] fp4_twice(logic [3:0] c);
    logic signed [4:0] v;
    case (c)
      4'd0:    v = 5'sd0;
      4'd1:    v = 5'sd1;
      4'd2:    v = 5'sd2;
      4'd3:    v = 5'sd3;
      4'd4:    v = 5'sd4;
      4'd5:    v = 5'sd6;
      4'd6:    v = 5'sd8;
      4'd7:    v = 5'sd12;
      4'd8:    v = 5'sd0;
      4'd9:    v = -5'sd1;
      4'd10:   v = -5'sd2;
      4'd11:   v = -5'sd3;
      4'd12:   v = -5'sd4;
      4'd13:   v = -5'sd6;
      4'd14:   v = -5'sd8;
      4'd15:   v = -5'sd12;
      default: v = 5'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] lead_zeros(logic [WordW-1:0] w);
    logic [6:0] n;
    n = 7'(WordW);
    for (int i = 0; i < WordW; i++) begin
      if (w[i]) n = 7'(WordW - 1 - i);
    end
    return n;
  endfunction

  function automatic pre_t f32_pre(logic [31:0] b);
    pre_t p;
    logic [7:0] e;
    logic signed [ExpW-1:0] ee;
    e      = b[30:23];
    ee     = ExpW'((e == 8'd0) ? 8'd1 : e);
    p.nan  = (e == 8'hFF) && (b[22:0] != 23'd0);
    p.inf  = (e == 8'hFF) && (b[22:0] == 23'd0);
    p.zero = (b[30:0] == 31'd0);
    p.sign = b[31];
    p.xp   = ee - ExpW'(127);
    p.word = {(e != 8'd0), b[22:0], {(WordW-24){1'b0}}};
    return p;
  endfunction

  // fp32(half) * 0.5 * fp32, exact.
  function automatic pre_t scale_pre(logic [15:0] h, logic [31:0] a);
    pre_t p;
    logic [4:0] eh;
    logic [7:0] ea;
    logic hn, hi, hz, an, ai, az;
    logic [34:0] prod;
    logic signed [ExpW-1:0] ehe, eae;
    eh     = h[14:10];
    ea     = a[30:23];
    hn     = (eh == 5'h1F) && (h[9:0] != 10'd0);
    hi     = (eh == 5'h1F) && (h[9:0] == 10'd0);
    hz     = (h[14:0] == 15'd0);
    an     = (ea == 8'hFF) && (a[22:0] != 23'd0);
    ai     = (ea == 8'hFF) && (a[22:0] == 23'd0);
    az     = (a[30:0] == 31'd0);
    p.nan  = hn | an | (hi & az) | (ai & hz);
    p.inf  = !p.nan & (hi | ai);
    p.zero = !p.nan & !p.inf & (hz | az);
    p.sign = h[15] ^ a[31];
    prod   = 35'({(eh != 5'd0), h[9:0]}) * 35'({(ea != 8'd0), a[22:0]});
    p.word = {prod, {(WordW-35){1'b0}}};
    ehe    = ExpW'((eh == 5'd0) ? 5'd1 : eh);
    eae    = ExpW'((ea == 8'd0) ? 8'd1 : ea);
    p.xp   = ehe + eae - ExpW'(142);
    return p;
  endfunction

  // Integer block dot times an fp32 scale, exact.
  function automatic pre_t dot_pre(logic signed [DotW-1:0] dot, logic [31:0] s);
    pre_t p;
    logic neg, dz, sn, si, sz;
    logic [7:0] se;
    logic [DotMagW-1:0] mag;
    logic [ProdW-1:0] prod;
    logic signed [ExpW-1:0] see;
    neg    = dot[DotW-1];
    mag    = DotMagW'(neg ? -dot : dot);
    dz     = (dot == '0);
    se     = s[30:23];
    sn     = (se == 8'hFF) && (s[22:0] != 23'd0);
    si     = (se == 8'hFF) && (s[22:0] == 23'd0);
    sz     = (s[30:0] == 31'd0);
    p.nan  = sn | (si & dz);
    p.inf  = !p.nan & si;
    p.zero = !p.nan & !p.inf & (dz | sz);
    p.sign = neg ^ s[31];
    prod   = ProdW'(mag) * ProdW'({(se != 8'd0), s[22:0]});
    p.word = {prod, {(WordW-ProdW){1'b0}}};
    see    = ExpW'((se == 8'd0) ? 8'd1 : se);
    p.xp   = see - ExpW'(150) + ExpW'(ProdW - 1);
    return p;
  endfunction

  function automatic unp_t norm(pre_t p);
    unp_t u;
    logic [6:0] lz;
    logic [WordW-1:0] sh;
    lz     = lead_zeros(p.word);
    sh     = p.word << lz;
    u.nan  = p.nan;
    u.inf  = p.inf & !p.nan;
    u.zero = !p.nan & !p.inf & (p.zero | (p.word == '0));
    u.sign = p.sign;
    u.xp   = p.xp - ExpW'(lz);
    u.frac = u.zero ? '0 : {sh[WordW-1:3], |sh[2:0]};
    return u;
  endfunction

  // Exact sum of two values; the low jam bit keeps rounding correct.
  function automatic pre_t add_pre(unp_t a, unp_t b);
    pre_t p;
    unp_t big, sml;
    logic a_big;
    logic signed [ExpW:0] d;
    logic [WordW-2:0] sf, sh;
    logic st;
    logic [WordW-1:0] bw, sw;
    p.nan = a.nan | b.nan | (a.inf & b.inf & (a.sign != b.sign));
    p.inf = !p.nan & (a.inf | b.inf);
    a_big = b.zero | (!a.zero & ((a.xp > b.xp) | ((a.xp == b.xp) & (a.frac >= b.frac))));
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    d     = (ExpW+1)'(big.xp) - (ExpW+1)'(sml.xp);
    sf    = {sml.frac, 1'b0};
    if (d >= (WordW - 1)) begin
      sh = '0;
      st = |sml.frac;
    end else begin
      sh = sf >> d[6:0];
      st = |(sf & (({{(WordW-2){1'b0}}, 1'b1} << d[6:0]) - 1'b1));
    end
    bw     = {1'b0, big.frac, 1'b0};
    sw     = {1'b0, sh[WordW-2:1], sh[0] | st};
    p.word = (a.sign != b.sign) ? (bw - sw) : (bw + sw);
    p.zero = !p.nan & !p.inf & a.zero & b.zero;
    if (p.inf) begin
      p.sign = a.inf ? a.sign : b.sign;
    end else if (a.zero & b.zero) begin
      p.sign = a.sign & b.sign;
    end else if (p.word == '0) begin
      p.sign = 1'b0;
    end else begin
      p.sign = big.sign;
    end
    p.xp = big.xp + ExpW'(1);
    return p;
  endfunction

  // Round to nearest-even fp32, subnormals and overflow included.
  function automatic logic [31:0] round_f32(unp_t v);
    logic signed [ExpW-1:0] be;
    logic [6:0] sh;
    logic [FracW-1:0] g, lmask;
    logic lost, guard, st, up;
    logic [23:0] f24;
    logic [24:0] m25;
    logic [31:0] r;
    be = v.xp + ExpW'(127);
    if (be >= 1) begin
      sh = 7'd0;
    end else if (be <= -62) begin
      sh = 7'd63;
    end else begin
      sh = 7'(1 - be);
    end
    lmask = ({{(FracW-1){1'b0}}, 1'b1} << sh) - 1'b1;
    lost  = |(v.frac & lmask);
    g     = v.frac >> sh;
    f24   = g[63:40];
    guard = g[39];
    st    = (|g[38:0]) | lost;
    up    = guard & (st | f24[0]);
    m25   = {1'b0, f24} + 25'(up);
    if (v.nan) begin
      r = CanonNan;
    end else if (v.inf) begin
      r = {v.sign, 8'hFF, 23'd0};
    end else if (v.zero) begin
      r = {v.sign, 31'd0};
    end else if (be >= 1) begin
      if (m25[24]) begin
        if (be + 1 >= 255) r = {v.sign, 8'hFF, 23'd0};
        else               r = {v.sign, 8'(be + 1), 23'd0};
      end else begin
        if (be >= 255) r = {v.sign, 8'hFF, 23'd0};
        else           r = {v.sign, be[7:0], m25[22:0]};
      end
    end else begin
      r = {v.sign, 7'd0, m25[23], m25[22:0]};
    end
    return r;
  endfunction

endpackage

>>> design/fp4_block_scaled_dot_product.sv
// Top level: FP4 x int8 block-scaled dot product with fp32 row accumulation.
// Throughput: one item per cycle while the back keeps pace with the closed blocks;
// short blocks fill the two-entry block queue and hold s_axis_tready low.
// At each block end the back scales, forms the exact product and accumulates with one rounding;
// at a row end it then adds the bias and offers row_sum once the output holds no unread result.
// Reset (asynchronous, active low) clears the block dot, the row sum to +0 and the queue.
module fp4_block_scaled_dot_product (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // code_byte[7:0], act_low[15:8], act_high[23:16], weight_scale[39:24],
  // act_scale[71:40], bias_value[103:72]
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // end_of_block
  input  logic         s_axis_tlast,  // end_of_row
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata   // row_sum[31:0]
);
  import fbsd_pkg::*;

  logic     q_full, q_empty, q_push, q_pop;
  blk_job_t push_job, head_job;

  // front: accumulate the exact integer dot, push each closed block
  fbsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .code_byte_i    (s_axis_tdata[7:0]),
    .act_low_i      ($signed(s_axis_tdata[15:8])),
    .act_high_i     ($signed(s_axis_tdata[23:16])),
    .weight_scale_i (s_axis_tdata[39:24]),
    .act_scale_i    (s_axis_tdata[71:40]),
    .bias_value_i   (s_axis_tdata[103:72]),
    .end_of_block_i (s_axis_tuser),
    .end_of_row_i   (s_axis_tlast),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .job_o          (push_job)
  );

  // hold closed blocks until the back is free
  fbsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  // back: scale, accumulate, add bias, drive the result transaction
  fbsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> design/fbsd_front.sv
// Front part: integer block dot per item, hands closed blocks to the queue.
module fbsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          code_byte_i,
  input  logic signed [7:0]   act_low_i,
  input  logic signed [7:0]   act_high_i,
  input  logic [15:0]         weight_scale_i,
  input  logic [31:0]         act_scale_i,
  input  logic [31:0]         bias_value_i,
  input  logic                end_of_block_i,
  input  logic                end_of_row_i,
  input  logic                q_full_i,
  output logic                push_o,
  output fbsd_pkg::blk_job_t  job_o
);
  import fbsd_pkg::*;

  logic signed [DotW-1:0]     block_dot_q, block_dot_d;
  logic signed [4:0]          w_lo, w_hi;
  logic signed [12:0]         p_lo, p_hi;
  logic signed [ContribW-1:0] contrib;
  logic signed [SumW-1:0]     sum;
  logic signed [DotW-1:0]     dot_sat;
  logic                       accept, closes;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign closes     = end_of_block_i | end_of_row_i;

  always_comb begin
    w_lo    = fp4_twice(code_byte_i[3:0]);
    w_hi    = fp4_twice(code_byte_i[7:4]);
    p_lo    = 13'(w_lo) * 13'(act_low_i);
    p_hi    = 13'(w_hi) * 13'(act_high_i);
    contrib = ContribW'(p_lo) + ContribW'(p_hi);
    sum     = SumW'(block_dot_q) + SumW'(contrib);
    // saturate an overlong block
    if (sum > SumW'(DotLimit)) begin
      dot_sat = DotW'(DotLimit);
    end else if (sum < SumW'(-DotLimit)) begin
      dot_sat = DotW'(-DotLimit);
    end else begin
      dot_sat = DotW'(sum);
    end
    block_dot_d = block_dot_q;
    if (accept) block_dot_d = closes ? '0 : dot_sat;
  end

  assign push_o             = accept & closes;
  assign job_o.dot          = dot_sat;
  assign job_o.weight_scale = weight_scale_i;
  assign job_o.act_scale    = act_scale_i;
  assign job_o.bias_value   = bias_value_i;
  assign job_o.end_of_row   = end_of_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_dot_q <= '0;
    end else begin
      block_dot_q <= block_dot_d;
    end
  end

endmodule

>>> design/fbsd_queue.sv
// Short queue of closed blocks between the front and the back.
module fbsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fbsd_pkg::blk_job_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output fbsd_pkg::blk_job_t head_o
);
  import fbsd_pkg::*;

  blk_job_t          entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign full_o  = (count_q == CountW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> design/fbsd_back.sv
// Back part: block scaling, fused accumulate and bias add on a shared fp32 datapath.
module fbsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  fbsd_pkg::blk_job_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_data_o
);
  import fbsd_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MUL_S = 11'b000_0000_0010,
    ST_NRM_S = 11'b000_0000_0100,
    ST_RND_S = 11'b000_0000_1000,
    ST_MUL_P = 11'b000_0001_0000,
    ST_NRM_B = 11'b000_0010_0000,
    ST_NRM_A = 11'b000_0100_0000,
    ST_ADD   = 11'b000_1000_0000,
    ST_NRM_R = 11'b001_0000_0000,
    ST_RND_R = 11'b010_0000_0000,
    ST_LOAD_B = 11'b100_0000_0000
  } back_state_e;

  back_state_e state_q, state_d;
  logic        bias_phase_q, bias_phase_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] out_data_q;
  blk_job_t    job_q;
  pre_t        pre_q;
  unp_t        opa_q, opb_q, val_q;
  logic [31:0] scale_q;
  logic [31:0] rnd;
  logic        emit;

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign rnd         = round_f32(val_q);
  assign emit        = (state_q == ST_RND_R) && bias_phase_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d      = state_q;
    bias_phase_d = bias_phase_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q & !out_ready_i;
    case (state_q)
      ST_IDLE:   if (!q_empty_i) state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_NRM_S;
      ST_NRM_S:  state_d = ST_RND_S;
      ST_RND_S:  state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_NRM_B;
      ST_NRM_B:  state_d = ST_NRM_A;
      ST_NRM_A:  state_d = ST_ADD;
      ST_ADD:    state_d = ST_NRM_R;
      ST_NRM_R:  state_d = ST_RND_R;
      ST_LOAD_B: state_d = ST_NRM_B;
      ST_RND_R: begin
        if (!bias_phase_q) begin
          acc_d = rnd;
          if (job_q.end_of_row) begin
            bias_phase_d = 1'b1;
            state_d      = ST_LOAD_B;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (emit) begin
          // hand over the row result, restart the row from +0
          out_valid_d  = 1'b1;
          acc_d        = '0;
          bias_phase_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bias_phase_q <= 1'b0;
      out_valid_q  <= 1'b0;
      acc_q        <= '0;
    end else begin
      state_q      <= state_d;
      bias_phase_q <= bias_phase_d;
      out_valid_q  <= out_valid_d;
      acc_q        <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_head_i;
    if (emit) out_data_q <= rnd;
    case (state_q)
      ST_MUL_S:  pre_q <= scale_pre(job_q.weight_scale, job_q.act_scale);
      ST_NRM_S:  val_q <= norm(pre_q);
      ST_RND_S:  scale_q <= rnd;
      ST_MUL_P:  pre_q <= dot_pre(job_q.dot, scale_q);
      ST_NRM_B: begin
        opb_q <= norm(pre_q);
        pre_q <= f32_pre(acc_q);
      end
      ST_NRM_A:  opa_q <= norm(pre_q);
      ST_ADD:    pre_q <= add_pre(opa_q, opb_q);
      ST_NRM_R:  val_q <= norm(pre_q);
      ST_LOAD_B: pre_q <= f32_pre(job_q.bias_value);
      default: ;
    endcase
  end

endmodule
